@@ src/tnmp_pkg.sv @@
package tnmp_pkg;

    localparam int unsigned NODE_W  = 16;
    localparam int unsigned DEPTH_W = 17;
    localparam int unsigned COST_W  = 18;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
    localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [COST_W-1:0]  t_cost;

endpackage

@@ src/tree_three_node_meeting_point_core.sv @@
// Channel | Direction | Handshake          | Payload
// in      | input     | i_valid / o_stall  | i_req_type, i_load_*, i_query_*
// out     | output    | o_valid / i_stall  | o_meet_node, o_total_cost
// A load does one jump-table read per level below the top one.
// A query runs six searches in the shared LCA unit, plus depth reads.
// One item is in work at a time; the input stalls until it is finished and
// the output register is free. Reset clears control only; the tables are
// undefined until loaded.
module tree_three_node_meeting_point_core #(
    parameter int unsigned MAX_NODES = 65536,
    parameter int unsigned LIFT_LEVELS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_req_type,
    input  tnmp_pkg::t_node        i_load_node,
    input  tnmp_pkg::t_node        i_load_parent,
    input  tnmp_pkg::t_node        i_query_a,
    input  tnmp_pkg::t_node        i_query_b,
    input  tnmp_pkg::t_node        i_query_c,
    output logic                   o_valid,
    input  logic                   i_stall,
    output tnmp_pkg::t_node        o_meet_node,
    output tnmp_pkg::t_cost        o_total_cost
);
    import tnmp_pkg::*;

    localparam int unsigned SLOT_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned LEVEL_W = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int unsigned JA_W    = SLOT_W + LEVEL_W;
    localparam logic [LEVEL_W-1:0] TOP_LVL = LEVEL_W'(LIFT_LEVELS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_LD_PD, S_LD_PDW, S_LD_RD, S_LD_RDW,
        S_Q_START, S_Q_WAIT1, S_Q_WAIT2,
        S_Q_D0, S_Q_D1, S_Q_D2, S_Q_D3, S_Q_D4, S_Q_D5,
        S_Q_EVAL, S_OUT
    } t_state;

    logic [NODE_W-1:0]  jump_mem [MAX_NODES * (2 ** LEVEL_W)];
    logic [DEPTH_W-1:0] depth_mem [MAX_NODES];

    t_state             r_state;
    t_node              r_a, r_b, r_c, r_node, r_par, r_cur;
    logic [LEVEL_W-1:0] r_lvl;
    logic [1:0]         r_pair;
    t_node              r_q1;
    t_depth             r_dx, r_dy, r_dz, r_dq1, r_dq2;
    logic               r_have;
    t_cost              r_best_cost;
    t_node              r_best_node;
    logic               r_valid;
    t_node              r_out_node;
    t_cost              r_out_cost;

    t_node              r_jrd_data;
    t_depth             r_drd_data;

    logic               r_ls;
    t_node              r_lu, r_lv;
    logic               lca_done, lca_jen, lca_den;
    t_node              lca_res;
    logic [JA_W-1:0]    lca_jaddr;
    logic [SLOT_W-1:0]  lca_daddr;

    logic               r_jen, r_den, r_jwe, r_dwe;
    logic [JA_W-1:0]    r_jaddr, r_jwaddr;
    logic [SLOT_W-1:0]  r_daddr, r_dwaddr;
    t_node              r_jwdata;
    t_depth             r_dwdata;

    logic [JA_W-1:0]    jrd_addr;
    logic [SLOT_W-1:0]  drd_addr;
    logic               jrd_en, drd_en;

    logic signed [DEPTH_W+3:0] cost_s;
    t_cost              cost_c;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_meet_node = r_out_node;
    assign o_total_cost = r_out_cost;

    assign jrd_en   = r_jen | lca_jen;
    assign jrd_addr = lca_jen ? lca_jaddr : r_jaddr;
    assign drd_en   = r_den | lca_den;
    assign drd_addr = lca_den ? lca_daddr : r_daddr;

    always_ff @(posedge i_clk) begin
        if (r_jwe) begin
            jump_mem[r_jwaddr] <= r_jwdata;
        end
        if (jrd_en) begin
            r_jrd_data <= jump_mem[jrd_addr];
        end
        if (r_dwe) begin
            depth_mem[r_dwaddr] <= r_dwdata;
        end
        if (drd_en) begin
            r_drd_data <= depth_mem[drd_addr];
        end
    end

    tnmp_lca #(
        .LEVEL_W(LEVEL_W),
        .LIFT_LEVELS(LIFT_LEVELS),
        .SLOT_W(SLOT_W)
    ) u_lca (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_ls),
        .i_u(r_lu),
        .i_v(r_lv),
        .o_done(lca_done),
        .o_lca(lca_res),
        .o_jrd_en(lca_jen),
        .o_jrd_addr(lca_jaddr),
        .i_jrd_data(r_jrd_data),
        .o_drd_en(lca_den),
        .o_drd_addr(lca_daddr),
        .i_drd_data(r_drd_data)
    );

    always_comb begin
        cost_s = $signed({4'b0, r_dx}) + $signed({4'b0, r_dy})
               - $signed({3'b0, r_dq1, 1'b0})
               + $signed({4'b0, r_dz}) + $signed({4'b0, r_dq1})
               - $signed({3'b0, r_dq2, 1'b0});
        if (cost_s < 0) begin
            cost_c = '0;
        end else if (cost_s > $signed({3'b0, COST_MAX})) begin
            cost_c = COST_MAX;
        end else begin
            cost_c = COST_W'(cost_s);
        end
    end

    function automatic logic [JA_W-1:0] jaddr(t_node n, logic [LEVEL_W-1:0] l);
        logic [SLOT_W-1:0] s;
        s = SLOT_W'(n);
        return {s, l};
    endfunction

    function automatic t_node pick_x(logic [1:0] p, t_node a, t_node b);
        return (p == 2'd1) ? b : a;
    endfunction

    always_ff @(posedge i_clk) begin
        r_jen <= 1'b0;
        r_den <= 1'b0;
        r_jwe <= 1'b0;
        r_dwe <= 1'b0;
        r_ls  <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_req_type == REQ_LOAD) begin
                            r_node <= i_load_node;
                            r_par <= i_load_parent;
                            r_den <= 1'b1;
                            r_daddr <= SLOT_W'(i_load_parent);
                            r_state <= S_LD_PD;
                        end else begin
                            r_a <= i_query_a;
                            r_b <= i_query_b;
                            r_c <= i_query_c;
                            r_pair <= 2'd0;
                            r_have <= 1'b0;
                            r_state <= S_Q_START;
                        end
                    end
                end
                S_LD_PD: begin
                    r_state <= S_LD_PDW;
                end
                S_LD_PDW: begin
                    r_dwe <= 1'b1;
                    r_dwaddr <= SLOT_W'(r_node);
                    if (r_node == r_par) begin
                        r_dwdata <= t_depth'(1);
                    end else if (r_drd_data == DEPTH_MAX) begin
                        r_dwdata <= DEPTH_MAX;
                    end else begin
                        r_dwdata <= r_drd_data + 1'b1;
                    end
                    r_jwe <= 1'b1;
                    r_jwaddr <= jaddr(r_node, '0);
                    r_jwdata <= r_par;
                    r_cur <= r_par;
                    r_lvl <= '0;
                    r_state <= (LIFT_LEVELS > 1) ? S_LD_RD : S_IDLE;
                end
                S_LD_RD: begin
                    r_jen <= 1'b1;
                    r_jaddr <= jaddr(r_cur, r_lvl);
                    r_state <= S_LD_RDW;
                end
                S_LD_RDW: begin
                    if (!r_jen) begin
                        r_jwe <= 1'b1;
                        r_jwaddr <= jaddr(r_node, r_lvl + 1'b1);
                        r_jwdata <= r_jrd_data;
                        r_cur <= r_jrd_data;
                        r_lvl <= r_lvl + 1'b1;
                        r_state <= (r_lvl + 1'b1 == TOP_LVL) ? S_IDLE : S_LD_RD;
                    end
                end
                S_Q_START: begin
                    r_ls <= 1'b1;
                    unique case (r_pair)
                        2'd0: begin r_lu <= r_a; r_lv <= r_b; end
                        2'd1: begin r_lu <= r_b; r_lv <= r_c; end
                        default: begin r_lu <= r_a; r_lv <= r_c; end
                    endcase
                    r_state <= S_Q_WAIT1;
                end
                S_Q_WAIT1: begin
                    if (lca_done) begin
                        r_q1 <= lca_res;
                        r_ls <= 1'b1;
                        unique case (r_pair)
                            2'd0: r_lu <= r_c;
                            2'd1: r_lu <= r_a;
                            default: r_lu <= r_b;
                        endcase
                        r_lv <= lca_res;
                        r_state <= S_Q_WAIT2;
                    end
                end
                S_Q_WAIT2: begin
                    if (lca_done) begin
                        r_cur <= lca_res;
                        r_den <= 1'b1;
                        r_daddr <= SLOT_W'(pick_x(r_pair, r_a, r_b));
                        r_state <= S_Q_D0;
                    end
                end
                S_Q_D0: begin
                    r_den <= 1'b1;
                    unique case (r_pair)
                        2'd0: r_daddr <= SLOT_W'(r_b);
                        default: r_daddr <= SLOT_W'(r_c);
                    endcase
                    r_state <= S_Q_D1;
                end
                S_Q_D1: begin
                    r_dx <= r_drd_data;
                    r_den <= 1'b1;
                    unique case (r_pair)
                        2'd0: r_daddr <= SLOT_W'(r_c);
                        2'd1: r_daddr <= SLOT_W'(r_a);
                        default: r_daddr <= SLOT_W'(r_b);
                    endcase
                    r_state <= S_Q_D2;
                end
                S_Q_D2: begin
                    r_dy <= r_drd_data;
                    r_den <= 1'b1;
                    r_daddr <= SLOT_W'(r_q1);
                    r_state <= S_Q_D3;
                end
                S_Q_D3: begin
                    r_dz <= r_drd_data;
                    r_den <= 1'b1;
                    r_daddr <= SLOT_W'(r_cur);
                    r_state <= S_Q_D4;
                end
                S_Q_D4: begin
                    r_dq1 <= r_drd_data;
                    r_state <= S_Q_D5;
                end
                S_Q_D5: begin
                    r_dq2 <= r_drd_data;
                    r_state <= S_Q_EVAL;
                end
                S_Q_EVAL: begin
                    if (!r_have || cost_c < r_best_cost) begin
                        r_best_cost <= cost_c;
                        r_best_node <= r_q1;
                    end
                    r_have <= 1'b1;
                    if (r_pair == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_pair <= r_pair + 1'b1;
                        r_state <= S_Q_START;
                    end
                end
                S_OUT: begin
                    if (!r_valid || !i_stall) begin
                        r_valid <= 1'b1;
                        r_out_node <= r_best_node;
                        r_out_cost <= r_best_cost;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/tnmp_lca.sv @@
module tnmp_lca #(
    parameter int unsigned LEVEL_W = 4,
    parameter int unsigned LIFT_LEVELS = 16,
    parameter int unsigned SLOT_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  tnmp_pkg::t_node          i_u,
    input  tnmp_pkg::t_node          i_v,
    output logic                     o_done,
    output tnmp_pkg::t_node          o_lca,
    output logic                     o_jrd_en,
    output logic [SLOT_W+LEVEL_W-1:0] o_jrd_addr,
    input  tnmp_pkg::t_node          i_jrd_data,
    output logic                     o_drd_en,
    output logic [SLOT_W-1:0]        o_drd_addr,
    input  tnmp_pkg::t_depth         i_drd_data
);
    import tnmp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DU, S_DV, S_GAP, S_LIFT, S_LIFTW, S_CMP,
        S_RU, S_RV, S_RVW, S_FIN, S_FINW
    } t_state;

    t_state              r_state;
    t_node               r_u, r_v, r_pu;
    t_depth              r_du;
    logic [DEPTH_W-1:0]  r_gap;
    logic [LEVEL_W-1:0]  r_lvl;
    logic                r_done;
    t_node               r_res;
    logic                r_jen, r_den;
    logic [SLOT_W+LEVEL_W-1:0] r_jaddr;
    logic [SLOT_W-1:0]   r_daddr;

    localparam logic [LEVEL_W-1:0] TOP_LVL = LEVEL_W'(LIFT_LEVELS - 1);

    assign o_done = r_done;
    assign o_lca = r_res;
    assign o_jrd_en = r_jen;
    assign o_jrd_addr = r_jaddr;
    assign o_drd_en = r_den;
    assign o_drd_addr = r_daddr;

    function automatic logic [SLOT_W+LEVEL_W-1:0] jaddr(t_node n, logic [LEVEL_W-1:0] l);
        logic [SLOT_W-1:0] s;
        s = SLOT_W'(n);
        return {s, l};
    endfunction

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        r_jen <= 1'b0;
        r_den <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_u <= i_u;
                        r_v <= i_v;
                        r_den <= 1'b1;
                        r_daddr <= SLOT_W'(i_u);
                        r_state <= S_DU;
                    end
                end
                S_DU: begin
                    r_den <= 1'b1;
                    r_daddr <= SLOT_W'(r_v);
                    r_state <= S_DV;
                end
                S_DV: begin
                    r_du <= i_drd_data;
                    r_state <= S_GAP;
                end
                S_GAP: begin
                    if (r_du < i_drd_data) begin
                        r_u <= r_v;
                        r_v <= r_u;
                        r_gap <= i_drd_data - r_du;
                    end else begin
                        r_gap <= r_du - i_drd_data;
                    end
                    r_lvl <= '0;
                    r_state <= S_LIFT;
                end
                S_LIFT: begin
                    if (r_gap[r_lvl]) begin
                        r_jen <= 1'b1;
                        r_jaddr <= jaddr(r_u, r_lvl);
                        r_state <= S_LIFTW;
                    end else if (r_lvl == TOP_LVL) begin
                        r_state <= S_CMP;
                    end else begin
                        r_lvl <= r_lvl + 1'b1;
                    end
                end
                S_LIFTW: begin
                    if (r_jen == 1'b0) begin
                        r_u <= i_jrd_data;
                        if (r_lvl == TOP_LVL) begin
                            r_state <= S_CMP;
                        end else begin
                            r_lvl <= r_lvl + 1'b1;
                            r_state <= S_LIFT;
                        end
                    end
                end
                S_CMP: begin
                    if (r_u == r_v) begin
                        r_res <= r_u;
                        r_done <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_lvl <= TOP_LVL;
                        r_jen <= 1'b1;
                        r_jaddr <= jaddr(r_u, TOP_LVL);
                        r_state <= S_RU;
                    end
                end
                S_RU: begin
                    r_jen <= 1'b1;
                    r_jaddr <= jaddr(r_v, r_lvl);
                    r_state <= S_RV;
                end
                S_RV: begin
                    r_pu <= i_jrd_data;
                    r_state <= S_RVW;
                end
                S_RVW: begin
                    if (r_pu != i_jrd_data) begin
                        r_u <= r_pu;
                        r_v <= i_jrd_data;
                    end
                    if (r_lvl == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_lvl <= r_lvl - 1'b1;
                        r_jen <= 1'b1;
                        r_jaddr <= jaddr((r_pu != i_jrd_data) ? r_pu : r_u, r_lvl - 1'b1);
                        r_state <= S_RU;
                    end
                end
                S_FIN: begin
                    r_jen <= 1'b1;
                    r_jaddr <= jaddr(r_u, '0);
                    r_state <= S_FINW;
                end
                S_FINW: begin
                    if (r_jen == 1'b0) begin
                        r_res <= i_jrd_data;
                        r_done <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
